// File: hdl/assert_macros.svh
// assertion macros shared by the beamformer rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock, off while reset is low
`define RPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// trigger in one cycle implies outcome in the next
`define RPP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/rpp_pkg.sv
// shared constants, types and the quarter-wave sine table of the beamformer
// no dependencies; imported by all rtl modules
package rpp_pkg;

  localparam int TABLE_BITS   = 10;
  localparam int GAIN_WIDTH   = 16;
  localparam int GAIN_FIELD_W = 16;
  localparam int PHASE_W      = 32;
  localparam int FRAC_BITS    = PHASE_W - TABLE_BITS;
  localparam int TAB_N        = 1 << TABLE_BITS;
  localparam int QUARTER      = TAB_N / 4;
  localparam int QBITS        = TABLE_BITS - 2;

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] GAIN_AMP = (64'd1 << (GAIN_WIDTH - 1)) - 64'd1;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic signed [GAIN_WIDTH-1:0] gain_t;
  typedef logic [QUARTER-1:0][GAIN_WIDTH-1:0] qtab_t;

  // register map, index = byte address / 4
  typedef enum logic [0:0] {
    REG_ENABLE = 1'b0,
    REG_STEP   = 1'b1
  } rpp_reg_t;

  // configuration seen by the phase update
  typedef struct packed {
    logic   enable;
    phase_t step_size;
  } rpp_cfg_t;

  // phase stage result handed to the lookup
  typedef struct packed {
    phase_t phase;
    logic   upd;
  } rpp_ph_t;

  // q30 taylor sine for 0..pi/2, clamped to one
  function automatic logic [63:0] taylor_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum;
  endfunction

  // magnitude of the sine at quarter-wave position m, elaboration only
  function automatic logic [GAIN_WIDTH-1:0] quarter_mag(input int m);
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] v;
    a = (64'd2 * PI_Q30 * 64'(m) + 64'(TAB_N / 2)) / 64'(TAB_N);
    s = taylor_sin(a);
    v = (s * GAIN_AMP + (ONE_Q30 >> 1)) >> 30;
    return v[GAIN_WIDTH-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int m = 0; m < QUARTER; m++) begin
      t[m] = quarter_mag(m);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam logic [GAIN_WIDTH-1:0] QPEAK = quarter_mag(QUARTER);

  // full-wave table entry k built from quarter-wave symmetry
  function automatic gain_t sine_at(input logic [TABLE_BITS-1:0] k);
    logic [1:0]            q;
    logic [QBITS-1:0]      m;
    logic [QBITS-1:0]      mr;
    logic [GAIN_WIDTH-1:0] mag;
    q  = k[TABLE_BITS-1 -: 2];
    m  = k[QBITS-1:0];
    mr = '0 - m;
    if (!q[0]) begin
      mag = QTAB[m];
    end else if (m == '0) begin
      mag = QPEAK;
    end else begin
      mag = QTAB[mr];
    end
    return q[1] ? -gain_t'(mag) : gain_t'(mag);
  endfunction

endpackage

// File: hdl/rpp_phase.sv
// input register and phase accumulator update of the beamformer
// depends on rpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpp_phase
  import rpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rpp_cfg_t          cfg,
  input  logic              in_valid,
  input  logic signed [1:0] in_feedback,
  input  logic              in_random_sign,
  output logic              in_stall,
  output logic              ph_valid,
  output rpp_ph_t           ph,
  input  logic              ph_ready
);

  logic              s1_valid_r;
  logic signed [1:0] s1_fb_r;
  logic              s1_sign_r;
  logic              s2_valid_r;
  rpp_ph_t           s2_r;
  rpp_ph_t           s2_nxt;

  phase_t            phase_acc_r;
  phase_t            phase_nxt;
  logic signed [1:0] prev_pert_r;
  logic signed [1:0] last_fb_r;

  logic   s1_ready;
  logic   s2_ready;
  logic   s1_adv;
  logic   fire;
  logic   undo;
  logic   prev_plus;
  phase_t delta;

  // pipeline flow control, bubbles fill even while the output waits
  assign s2_ready = !s2_valid_r || ph_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  // update when enabled and the feedback is new and nonzero
  assign fire      = cfg.enable && (s1_fb_r != 2'sd0) && (s1_fb_r != last_fb_r);
  assign undo      = s1_fb_r[1] && (prev_pert_r != 2'sd0);
  assign prev_plus = !prev_pert_r[1];

  function automatic phase_t in_sign_step(input logic plus, input phase_t s);
    return plus ? s : ('0 - s);
  endfunction

  // net phase step: new perturbation plus, on negative feedback, the undo of the previous one
  always_comb begin
    if (!undo) begin
      delta = in_sign_step(s1_sign_r, cfg.step_size);
    end else if (s1_sign_r == prev_plus) begin
      delta = '0;
    end else begin
      delta = in_sign_step(s1_sign_r, cfg.step_size << 1);
    end
    phase_nxt     = phase_acc_r + delta;
    s2_nxt.phase  = phase_nxt;
    s2_nxt.upd    = fire;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_fb_r   <= in_feedback;
      s1_sign_r <= in_random_sign;
    end
  end

  // phase state, committed as an item that fires an update leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      prev_pert_r <= 2'sd0;
      last_fb_r   <= 2'sd0;
    end else if (s1_adv && fire) begin
      phase_acc_r <= phase_nxt;
      prev_pert_r <= s1_sign_r ? 2'sd1 : -2'sd1;
      last_fb_r   <= s1_fb_r;
    end
  end

  // phase result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign ph_valid = s2_valid_r;
  assign ph       = s2_r;

  `RPP_ASSERT_NEXT(a_fire_reaches_s2, s1_adv && fire,
    s2_valid_r && s2_r.upd && (s2_r.phase == phase_acc_r),
    "phase update did not reach the phase register")
  `RPP_ASSERT_NEXT(a_state_holds, !(s1_adv && fire),
    $stable(phase_acc_r) && $stable(last_fb_r) && $stable(prev_pert_r),
    "phase state changed without an update")

endmodule

// File: hdl/rpp_lookup.sv
// interpolated sine/cosine lookup and gain register of the beamformer
// depends on rpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpp_lookup
  import rpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    ph_valid,
  input  rpp_ph_t ph,
  output logic    ph_ready,
  output logic    out_valid,
  input  logic    out_stall,
  output gain_t   gain_re,
  output gain_t   gain_im,
  output logic    updated
);

  localparam int DW = GAIN_WIDTH + 1;
  localparam int PW = DW + FRAC_BITS + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    gain_t                sin_a;
    gain_t                sin_b;
    gain_t                cos_a;
    gain_t                cos_b;
    logic [FRAC_BITS-1:0] frac;
    logic                 upd;
  } rpp_tap_t;

  logic     s3_valid_r;
  rpp_tap_t s3_r;
  rpp_tap_t s3_nxt;
  logic     out_valid_r;
  gain_t    gain_re_r;
  gain_t    gain_im_r;
  logic     upd_r;

  logic s3_ready;
  logic s4_ready;
  logic [TABLE_BITS-1:0] idx_s;
  logic [TABLE_BITS-1:0] idx_s1;
  logic [TABLE_BITS-1:0] idx_c;
  logic [TABLE_BITS-1:0] idx_c1;

  // a + floor((b - a) * f / 2^frac + 1/2)
  function automatic gain_t interp(input gain_t a, input gain_t b,
                                   input logic [FRAC_BITS-1:0] f);
    logic signed [DW-1:0]        d;
    logic signed [FRAC_BITS:0]   fs;
    logic signed [PW-1:0]        p;
    logic signed [DW-1:0]        r;
    d  = DW'(b) - DW'(a);
    fs = $signed({1'b0, f});
    p  = d * fs + HALF;
    r  = DW'(a) + DW'(p >>> FRAC_BITS);
    return r[GAIN_WIDTH-1:0];
  endfunction

  assign s4_ready = !out_valid_r || !out_stall;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign ph_ready = s3_ready;

  // table reads, cosine is the sine a quarter turn ahead
  always_comb begin
    idx_s         = ph.phase[PHASE_W-1 -: TABLE_BITS];
    idx_s1        = idx_s + TABLE_BITS'(1);
    idx_c         = idx_s + TABLE_BITS'(QUARTER);
    idx_c1        = idx_c + TABLE_BITS'(1);
    s3_nxt.sin_a  = sine_at(idx_s);
    s3_nxt.sin_b  = sine_at(idx_s1);
    s3_nxt.cos_a  = sine_at(idx_c);
    s3_nxt.cos_b  = sine_at(idx_c1);
    s3_nxt.frac   = ph.phase[FRAC_BITS-1:0];
    s3_nxt.upd    = ph.upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= ph_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && ph_valid) begin
      s3_r <= s3_nxt;
    end
  end

  // result register, gain kept until an update passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      gain_re_r   <= gain_t'(GAIN_AMP[GAIN_WIDTH-1:0]);
      gain_im_r   <= '0;
    end else if (s4_ready) begin
      out_valid_r <= s3_valid_r;
      if (s3_valid_r && s3_r.upd) begin
        gain_re_r <= interp(s3_r.cos_a, s3_r.cos_b, s3_r.frac);
        gain_im_r <= interp(s3_r.sin_a, s3_r.sin_b, s3_r.frac);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid_r) begin
      upd_r <= s3_r.upd;
    end
  end

  assign out_valid = out_valid_r;
  assign gain_re   = gain_re_r;
  assign gain_im   = gain_im_r;
  assign updated   = upd_r;

  `RPP_ASSERT_NEXT(a_gain_held, !(s4_ready && s3_valid_r && s3_r.upd),
    $stable(gain_re_r) && $stable(gain_im_r),
    "gain changed without an update transfer")

endmodule

// File: hdl/random_phase_perturbation_beamformer.sv
// Random phase perturbation beamformer with one-bit feedback.
// Input channel (in_valid/in_stall): one transfer per feedback sample, carrying
// in_feedback (2-bit signed) and in_random_sign. Result channel
// (out_valid/out_stall): exactly one transfer per input, carrying the current
// complex gain (cos/sin of the phase, Q1.15) and out_updated.
// Configuration through the APB-style port: enable at 0x0, step_size at 0x4;
// write only while no item is in flight.
// Path: an input passes the input, phase, table and result registers in turn.
// Throughput: one item per cycle while out_stall is low; the phase accumulator add and one table
// lookup each fit in a single stage, so every stage takes a new item each cycle unless held.
// Stall: each stage holds while the one after it is full and stalled; empty
// stages keep filling, so up to four items sit in the block before in_stall.
// Reset (rst_n low, synchronous): phase zero, no previous perturbation, last
// feedback zero, gain real full scale and imaginary zero, enable and step zero,
// both channels empty. The sine table is constant, no clearing pass is needed.
// Depends on rpp_pkg, rpp_phase and rpp_lookup.
module random_phase_perturbation_beamformer
  import rpp_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [1:0]              in_feedback,
  input  logic                           in_random_sign,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [GAIN_FIELD_W-1:0] out_gain_real,
  output logic signed [GAIN_FIELD_W-1:0] out_gain_imag,
  output logic                           out_updated,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic     enable_r;
  phase_t   step_r;
  rpp_cfg_t cfg;
  rpp_reg_t reg_sel;
  logic     cfg_wr;

  logic    ph_valid;
  logic    ph_ready;
  rpp_ph_t ph;
  gain_t   gain_re;
  gain_t   gain_im;
  logic signed [31:0] re_ext;
  logic signed [31:0] im_ext;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = rpp_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      step_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ENABLE: enable_r <= pwdata[0];
        REG_STEP:   step_r   <= pwdata;
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_ENABLE: prdata = {31'b0, enable_r};
      REG_STEP:   prdata = step_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg.enable    = enable_r;
  assign cfg.step_size = step_r;

  rpp_phase u_phase (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_feedback    (in_feedback),
    .in_random_sign (in_random_sign),
    .in_stall       (in_stall),
    .ph_valid       (ph_valid),
    .ph             (ph),
    .ph_ready       (ph_ready)
  );

  rpp_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .ph_valid  (ph_valid),
    .ph        (ph),
    .ph_ready  (ph_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gain_re   (gain_re),
    .gain_im   (gain_im),
    .updated   (out_updated)
  );

  // gain width to field width
  assign re_ext        = 32'(gain_re);
  assign im_ext        = 32'(gain_im);
  assign out_gain_real = re_ext[GAIN_FIELD_W-1:0];
  assign out_gain_imag = im_ext[GAIN_FIELD_W-1:0];

endmodule
